// ----- sv/pre_pkg.sv -----
// Package for the polyline ribbon expander: payload structs, widths and codes.
// No dependencies.
`default_nettype none
package pre_pkg;
  localparam int unsigned CoordW = 16;
  localparam int unsigned ThickW = 12;
  localparam int unsigned DiffW = 17;
  localparam int unsigned SqW = 35;
  localparam int unsigned RadW = 51;
  localparam int unsigned LenW = 26;
  localparam int unsigned NumW = 36;
  localparam int unsigned QuoW = 37;
  localparam logic [11:0] ThickReset = 12'd240;
  localparam logic [0:0] AddrThick = 1'b0;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic end_of_line;
  } point_t;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic final_vertex;
  } vertex_t;

  // job from front to back: segment to expand
  typedef struct packed {
    logic signed [CoordW-1:0] qx;
    logic signed [CoordW-1:0] qy;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic eol;
  } seg_t;
endpackage
`default_nettype wire

// ----- sv/pre_if.sv -----
// Valid/ready stream interfaces for points and strip vertices.
// Depends on pre_pkg for the payload structs.
`default_nettype none
interface pre_point_if;
  import pre_pkg::*;
  logic valid;
  logic ready;
  point_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pre_vertex_if;
  import pre_pkg::*;
  logic valid;
  logic ready;
  vertex_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/pre_front.sv -----
// Front end: accepts points, tracks the previous point, issues segment jobs.
// Depends on pre_pkg and pre_if.
`default_nettype none
module pre_front (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pre_point_if.sink pt,
  output pre_pkg::seg_t job_o,
  output logic job_valid_o,
  input  wire logic job_ready_i
);
  import pre_pkg::*;
  logic have_q, have_d;
  logic signed [CoordW-1:0] prev_x_q, prev_y_q;
  logic acc;

  assign pt.ready = job_ready_i;
  assign acc = pt.valid && job_ready_i;
  assign job_valid_o = pt.valid && have_q;
  assign job_o = '{qx: prev_x_q, qy: prev_y_q, px: pt.data.point_x,
                   py: pt.data.point_y, eol: pt.data.end_of_line};

  always_comb begin
    have_d = have_q;
    if (acc) have_d = !pt.data.end_of_line;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      prev_x_q <= '0;
      prev_y_q <= '0;
    end else begin
      have_q <= have_d;
      if (acc && (have_q || !pt.data.end_of_line)) begin
        prev_x_q <= pt.data.point_x;
        prev_y_q <= pt.data.point_y;
      end
    end
  end
endmodule
`default_nettype wire

// ----- sv/pre_queue.sv -----
// Two-entry queue for segment jobs between the front and back ends.
// Depends on pre_pkg.
`default_nettype none
module pre_queue (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire pre_pkg::seg_t in_i,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  output pre_pkg::seg_t out_o,
  output logic out_valid_o,
  input  wire logic out_ready_i
);
  import pre_pkg::*;
  seg_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign in_ready_o = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_o = mem_q[rp_q];
  assign wr = in_valid_i && in_ready_o;
  assign rd = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

// ----- sv/pre_back.sv -----
// Back end: square, iterative square root, iterative dividers, vertex emit.
// Depends on pre_pkg and pre_if.
`default_nettype none
module pre_back (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic [pre_pkg::ThickW-1:0] thick_i,
  input  wire pre_pkg::seg_t job_i,
  input  wire logic job_valid_i,
  output logic job_ready_o,
  pre_vertex_if.source vx
);
  import pre_pkg::*;
  typedef enum logic [6:0] {
    SIdle = 7'b0000001, SSq = 7'b0000010, SMul = 7'b0000100,
    SRoot = 7'b0001000, SDiv = 7'b0010000, SRnd = 7'b0100000,
    SEmit = 7'b1000000
  } state_e;
  state_e st_q, st_d;
  seg_t job_q;
  logic signed [DiffW-1:0] dx_q, dy_q;
  logic [SqW-1:0] s_q;
  logic [RadW-1:0] rem_q;
  logic [LenW-1:0] root_q;
  logic [5:0] cnt_q;
  logic [NumW-1:0] nx_q, ny_q;
  logic [QuoW-1:0] rx_q, ry_q;
  logic [NumW-1:0] qx_q, qy_q;
  logic sx_q, sy_q;
  logic signed [CoordW:0] ox_q, oy_q;
  logic [1:0] k_q;

  // one root step: two radicand bits per cycle
  logic [LenW+1:0] rtest;
  logic [2*LenW-1:0] rad;
  logic [1:0] rpair;
  logic [RadW+1:0] rcur, rsub;
  assign rtest = {root_q, 2'b01};
  assign rad = {1'b0, s_q, 16'd0};
  assign rpair = rad[2*cnt_q[4:0] +: 2];
  assign rcur = {rem_q, rpair};
  assign rsub = rcur - {{(RadW-LenW){1'b0}}, rtest};

  // one divide step per component
  logic [QuoW:0] xsh, ysh, xt, yt;
  assign xsh = {rx_q, nx_q[NumW-1]};
  assign ysh = {ry_q, ny_q[NumW-1]};
  assign xt = xsh - {{(QuoW-LenW+1){1'b0}}, root_q};
  assign yt = ysh - {{(QuoW-LenW+1){1'b0}}, root_q};

  logic [NumW-1:0] ax, ay;
  assign ax = dy_q[DiffW-1] ? NumW'(-$signed(dy_q)) : NumW'(dy_q);
  assign ay = dx_q[DiffW-1] ? NumW'(-$signed(dx_q)) : NumW'(dx_q);

  // output vertex
  logic signed [CoordW+1:0] bx, by, vxs, vys;
  always_comb begin
    bx = k_q[1] ? {{2{job_q.px[CoordW-1]}}, job_q.px} : {{2{job_q.qx[CoordW-1]}}, job_q.qx};
    by = k_q[1] ? {{2{job_q.py[CoordW-1]}}, job_q.py} : {{2{job_q.qy[CoordW-1]}}, job_q.qy};
    vxs = k_q[0] ? bx + {ox_q[CoordW], ox_q} : bx - {ox_q[CoordW], ox_q};
    vys = k_q[0] ? by + {oy_q[CoordW], oy_q} : by - {oy_q[CoordW], oy_q};
  end
  function automatic logic [CoordW-1:0] sat(input logic signed [CoordW+1:0] v);
    if (v > 18'sd32767) return 16'h7fff;
    else if (v < -18'sd32768) return 16'h8000;
    else return v[CoordW-1:0];
  endfunction
  assign vx.valid = st_q == SEmit;
  assign vx.data = '{vertex_x: sat(vxs), vertex_y: sat(vys),
                     final_vertex: (k_q == 2'd1 && !job_q.eol) || k_q == 2'd3};
  assign job_ready_o = st_q == SIdle;

  logic signed [QuoW:0] rqx, rqy;
  assign rqx = $signed({2'b00, qx_q});
  assign rqy = $signed({2'b00, qy_q});

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      SIdle: if (job_valid_i) st_d = SSq;
      SSq: st_d = SMul;
      SMul: st_d = (s_q == '0) ? SEmit : SRoot;
      SRoot: if (cnt_q == 6'd0) st_d = SDiv;
      SDiv: if (cnt_q == 6'd0) st_d = SRnd;
      SRnd: st_d = SEmit;
      SEmit: if (vx.ready && (k_q == 2'd3 || (k_q == 2'd1 && !job_q.eol))) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      k_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == SMul) k_q <= '0;
      else if (st_q == SEmit && vx.ready) k_q <= k_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      SIdle: if (job_valid_i) begin
        job_q <= job_i;
        dx_q <= {job_i.px[CoordW-1], job_i.px} - {job_i.qx[CoordW-1], job_i.qx};
        dy_q <= {job_i.py[CoordW-1], job_i.py} - {job_i.qy[CoordW-1], job_i.qy};
      end
      SSq: s_q <= SqW'($signed(dx_q) * $signed(dx_q)) + SqW'($signed(dy_q) * $signed(dy_q));
      SMul: begin
        nx_q <= NumW'(ax * {thick_i, 7'd0});
        ny_q <= NumW'(ay * {thick_i, 7'd0});
        sx_q <= !dy_q[DiffW-1] && dy_q != '0;
        sy_q <= dx_q[DiffW-1];
        rem_q <= '0;
        root_q <= '0;
        cnt_q <= 6'd25;
        ox_q <= '0;
        oy_q <= '0;
      end
      SRoot: begin
        if (!rsub[RadW+1]) begin
          rem_q <= rsub[RadW-1:0];
          root_q <= {root_q[LenW-2:0], 1'b1};
        end else begin
          rem_q <= rcur[RadW-1:0];
          root_q <= {root_q[LenW-2:0], 1'b0};
        end
        if (cnt_q == 6'd0) begin
          cnt_q <= 6'd35;
          rx_q <= '0;
          ry_q <= '0;
        end else cnt_q <= cnt_q - 6'd1;
      end
      SDiv: begin
        rx_q <= xt[QuoW] ? xsh[QuoW-1:0] : xt[QuoW-1:0];
        ry_q <= yt[QuoW] ? ysh[QuoW-1:0] : yt[QuoW-1:0];
        nx_q <= {nx_q[NumW-2:0], 1'b0};
        ny_q <= {ny_q[NumW-2:0], 1'b0};
        qx_q <= {qx_q[NumW-2:0], !xt[QuoW]};
        qy_q <= {qy_q[NumW-2:0], !yt[QuoW]};
        if (cnt_q != 6'd0) cnt_q <= cnt_q - 6'd1;
      end
      SRnd: begin
        // round half away: bump when 2*rem >= len
        ox_q <= (CoordW+1)'(sx_q ?
          -(rqx + (({rx_q, 1'b0} >= {{(QuoW-LenW+1){1'b0}}, root_q}) ? 1 : 0)) :
           (rqx + (({rx_q, 1'b0} >= {{(QuoW-LenW+1){1'b0}}, root_q}) ? 1 : 0)));
        oy_q <= (CoordW+1)'(sy_q ?
          -(rqy + (({ry_q, 1'b0} >= {{(QuoW-LenW+1){1'b0}}, root_q}) ? 1 : 0)) :
           (rqy + (({ry_q, 1'b0} >= {{(QuoW-LenW+1){1'b0}}, root_q}) ? 1 : 0)));
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- sv/polyline_ribbon_expander.sv -----
// Top level: APB register, front end, job queue and back end.
// Depends on pre_pkg, pre_if, pre_front, pre_queue, pre_back.
//
// Usage: points enter on pt_i (valid/ready); strip vertices leave on vx_o.
// Each point after the first of a polyline yields two vertices, four with
// end_of_line; a lone or first point yields none. A point is taken only while
// the queue has room. With the back end idle, the first vertex of a point is
// valid once the point has passed the queue, the square, the scale, the
// square root and the restoring divide (one result bit per cycle each) and
// the round step. The back end then emits one vertex per cycle while the
// receiver is ready and takes its next job the cycle after the last; a
// zero-length segment skips root and divide. The two-entry queue lets the
// front end take points while the back end works. Reset clears the previous
// point and sets line_thickness to 240. When the receiver stalls the current
// vertex holds and the back end waits; once the queue fills, pt_i ready
// drops. Register line_thickness sits at address 0.
`default_nettype none
module polyline_ribbon_expander (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pre_point_if.sink pt_i,
  pre_vertex_if.source vx_o,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [0:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import pre_pkg::*;
  logic [ThickW-1:0] thick_q;
  seg_t fj, bj;
  logic fv, fr, bv, br;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrThick) ? {20'd0, thick_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thick_q <= ThickReset;
    else if (psel && penable && pwrite && paddr == AddrThick) thick_q <= pwdata[ThickW-1:0];
  end

  pre_front u_front (.clk_i, .rst_ni, .pt(pt_i), .job_o(fj), .job_valid_o(fv),
                     .job_ready_i(fr));
  pre_queue u_queue (.clk_i, .rst_ni, .in_i(fj), .in_valid_i(fv), .in_ready_o(fr),
                     .out_o(bj), .out_valid_o(bv), .out_ready_i(br));
  pre_back u_back (.clk_i, .rst_ni, .thick_i(thick_q), .job_i(bj), .job_valid_i(bv),
                   .job_ready_o(br), .vx(vx_o));
endmodule
`default_nettype wire

// ----- sv/pre_checker.sv -----
// Port-level checker for the ribbon expander, bound to the top level.
// Depends on polyline_ribbon_expander, the bind target.
`default_nettype none
module pre_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic pv, pr, vv, vr, vf, pready
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vv && !vr |=> vv) else $error("vertex dropped");
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv && !pr |=> pv) else $error("point withdrawn");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vv && vr && vf |=> !vv) else $error("vertex right after final");
endmodule
bind polyline_ribbon_expander pre_checker u_chk (.clk_i, .rst_ni,
  .pv(pt_i.valid), .pr(pt_i.ready), .vv(vx_o.valid), .vr(vx_o.ready),
  .vf(vx_o.data.final_vertex), .pready(pready));
`default_nettype wire
